@@ hw/rtl/rnea_pkg.sv @@
package rnea_pkg;

    localparam int MAX_AGENTS = 32;
    localparam int IDX_W      = $clog2(MAX_AGENTS);
    localparam int CNT_W      = $clog2(MAX_AGENTS + 1);

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(5);

    // Both queues between the stages are two words deep.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        idx_t idx;
        logic bad;
    } cmd_t;

    typedef struct packed {
        idx_t agent;
        idx_t first_res;
        idx_t second_res;
        logic bad;
        logic last;
    } result_t;

    function automatic cnt_t ring_size(cnt_t n);
        cnt_t c;
        c = n;
        if (n == '0)
        begin
            c = cnt_t'(1);
        end
        else if (n > cnt_t'(MAX_AGENTS))
        begin
            c = cnt_t'(MAX_AGENTS);
        end
        return c;
    endfunction

    function automatic idx_t left_of(idx_t i, cnt_t c);
        idx_t o;
        if (i == '0)
        begin
            o = idx_t'(c - cnt_t'(1));
        end
        else
        begin
            o = i - idx_t'(1);
        end
        return o;
    endfunction

    function automatic idx_t right_of(idx_t i, cnt_t c);
        cnt_t nxt;
        idx_t o;
        nxt = cnt_t'(i) + cnt_t'(1);
        if (nxt >= c)
        begin
            o = '0;
        end
        else
        begin
            o = idx_t'(nxt);
        end
        return o;
    endfunction

    function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
        logic [Q_PTR_W-1:0] o;
        if (p == Q_PTR_W'(Q_DEPTH - 1))
        begin
            o = '0;
        end
        else
        begin
            o = p + Q_PTR_W'(1);
        end
        return o;
    endfunction

endpackage

@@ hw/rtl/rnea_front.sv @@
module rnea_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rnea_pkg::idx_t       agent_index,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  rnea_pkg::cnt_t       cfg_agent_count,
    input  logic                 cmd_pop,
    output logic                 cmd_empty,
    output rnea_pkg::cmd_t       cmd_head,
    output rnea_pkg::cnt_t       ring_size
);

    rnea_pkg::cnt_t                   agent_count_reg;
    rnea_pkg::cmd_t                   mem_reg [rnea_pkg::Q_DEPTH];
    logic [rnea_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rnea_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rnea_pkg::Q_CNT_W-1:0]     fill_reg, fill_next;
    logic                             accept;
    rnea_pkg::cmd_t                   entry;

    assign cfg_ready = 1'b1;
    assign ring_size = rnea_pkg::ring_size(agent_count_reg);

    assign full      = (fill_reg == rnea_pkg::Q_CNT_W'(rnea_pkg::Q_DEPTH));
    assign cmd_empty = (fill_reg == '0);
    assign accept    = push && !full;
    assign cmd_head  = mem_reg[rd_ptr_reg];

    // An index at or beyond the ring size is marked here so the back end
    // only has to look at the agent states.
    always_comb
    begin
        entry.idx = agent_index;
        entry.bad = ({1'b0, agent_index} >= ring_size);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            wr_ptr_next = rnea_pkg::ptr_inc(wr_ptr_reg);
        end
        if (cmd_pop && !cmd_empty)
        begin
            rd_ptr_next = rnea_pkg::ptr_inc(rd_ptr_reg);
        end
        if (accept && !(cmd_pop && !cmd_empty))
        begin
            fill_next = fill_reg + rnea_pkg::Q_CNT_W'(1);
        end
        else if (!accept && cmd_pop && !cmd_empty)
        begin
            fill_next = fill_reg - rnea_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agent_count_reg <= rnea_pkg::COUNT_RESET;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                agent_count_reg <= cfg_agent_count;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

@@ hw/rtl/rnea_back.sv @@
module rnea_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rnea_pkg::cnt_t       ring_size,
    input  logic                 cmd_empty,
    input  rnea_pkg::cmd_t       cmd_head,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output rnea_pkg::result_t    res_word
);

    typedef enum logic [1:0] {
        B_RUN    = 2'b01,
        B_SECOND = 2'b10
    } back_state_t;

    localparam logic [rnea_pkg::MAX_AGENTS-1:0] ONE = rnea_pkg::MAX_AGENTS'(1);

    back_state_t                      state_reg, state_next;
    logic [rnea_pkg::MAX_AGENTS-1:0]  waiting_reg, waiting_next;
    logic [rnea_pkg::MAX_AGENTS-1:0]  eating_reg, eating_next;
    rnea_pkg::result_t                pend_reg, pend_next;

    rnea_pkg::idx_t                   i, l, r, ll, rr;
    logic [rnea_pkg::MAX_AGENTS-1:0]  one_i, one_l, one_r;
    logic [rnea_pkg::MAX_AGENTS-1:0]  eat1, eat2, eat3, wait2, wait3;
    logic                             was_eating, bad, req_grant, gl, gr;

    assign i  = cmd_head.idx;
    assign l  = rnea_pkg::left_of(i, ring_size);
    assign r  = rnea_pkg::right_of(i, ring_size);
    assign ll = rnea_pkg::left_of(l, ring_size);
    assign rr = rnea_pkg::right_of(r, ring_size);

    assign one_i = ONE << i;
    assign one_l = ONE << l;
    assign one_r = ONE << r;

    assign was_eating = eating_reg[i];
    assign bad        = cmd_head.bad || waiting_reg[i];
    assign req_grant  = !eating_reg[l] && !eating_reg[r];

    // A release is resolved in order: the left neighbour is checked first,
    // and the right check sees the state that the left grant left behind.
    always_comb
    begin
        eat1  = eating_reg & ~one_i;
        gl    = waiting_reg[l] && !eat1[ll];
        eat2  = gl ? (eat1 | one_l) : eat1;
        wait2 = gl ? (waiting_reg & ~one_l) : waiting_reg;
        gr    = wait2[r] && !eat2[rr];
        eat3  = gr ? (eat2 | one_r) : eat2;
        wait3 = gr ? (wait2 & ~one_r) : wait2;
    end

    always_comb
    begin
        state_next   = state_reg;
        waiting_next = waiting_reg;
        eating_next  = eating_reg;
        pend_next    = pend_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_word     = '0;
        case (state_reg)
            B_RUN:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (bad)
                    begin
                        res_push = 1'b1;
                        res_word = '{agent: i, first_res: '0, second_res: '0,
                                     bad: 1'b1, last: 1'b1};
                    end
                    else if (!was_eating)
                    begin
                        if (req_grant)
                        begin
                            eating_next = eating_reg | one_i;
                            res_push    = 1'b1;
                            res_word    = '{agent: i, first_res: i, second_res: r,
                                            bad: 1'b0, last: 1'b1};
                        end
                        else
                        begin
                            waiting_next = waiting_reg | one_i;
                        end
                    end
                    else
                    begin
                        eating_next  = eat3;
                        waiting_next = wait3;
                        if (gl)
                        begin
                            res_push = 1'b1;
                            res_word = '{agent: l, first_res: l, second_res: i,
                                         bad: 1'b0, last: !gr};
                        end
                        if (gr)
                        begin
                            if (gl)
                            begin
                                pend_next  = '{agent: r, first_res: r, second_res: rr,
                                               bad: 1'b0, last: 1'b1};
                                state_next = B_SECOND;
                            end
                            else
                            begin
                                res_push = 1'b1;
                                res_word = '{agent: r, first_res: r, second_res: rr,
                                             bad: 1'b0, last: 1'b1};
                            end
                        end
                    end
                end
            end
            B_SECOND:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    res_word   = pend_reg;
                    state_next = B_RUN;
                end
            end
            default:
            begin
                state_next = B_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_RUN;
            waiting_reg <= '0;
            eating_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            waiting_reg <= waiting_next;
            eating_reg  <= eating_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_wait_eat_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        !(|(waiting_reg & eating_reg)))
        else $error("agent both waiting and eating");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full queue");

    a_second_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SECOND) |-> !cmd_pop)
        else $error("command taken while a second grant is pending");

    a_grant_eats: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_word.bad) |=> eating_reg[$past(res_word.agent)])
        else $error("granted agent is not eating");

endmodule

@@ hw/rtl/rnea_outq.sv @@
module rnea_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rnea_pkg::result_t    word,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output rnea_pkg::result_t    head
);

    rnea_pkg::result_t                mem_reg [rnea_pkg::Q_DEPTH];
    logic [rnea_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rnea_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rnea_pkg::Q_CNT_W-1:0]     fill_reg, fill_next;
    logic                             do_push, do_pop;

    assign full    = (fill_reg == rnea_pkg::Q_CNT_W'(rnea_pkg::Q_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? rnea_pkg::ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rnea_pkg::ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + rnea_pkg::Q_CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - rnea_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= word;
        end
    end

endmodule

@@ hw/rtl/ring_neighbor_exclusion_arbiter.sv @@
// Waiter-style arbiter for agents on a ring; each agent needs the resources
// it shares with both neighbours. Events enter through a queue-like port:
// a word is taken on a clock edge with push high and full low. Results
// leave the same way: the oldest result sits on the result ports while
// empty is low and is taken on an edge with pop high.
// The ring size is written through the cfg_valid/cfg_ready channel, which
// is always ready; it is to be written only while the block is idle.
// A result word passes through the command queue and the result queue
// before it reaches the result ports. The executing stage finishes an
// event when it takes its command; when a release hands both neighbours
// their resources, the second result word waits in a pending register
// for the B_SECOND state, since the result queue has a single write port.
// The block sustains one event per cycle while the result queue has room
// and no second grant is pending. Reset marks every agent as talking,
// sets the ring size to five and empties both two-word queues. When the
// receiver stops popping, the result queue fills, the executing stage
// holds its command, the command queue fills and full rises.
module ring_neighbor_exclusion_arbiter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [4:0]           agent_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [4:0]           granted_agent,
    output logic [4:0]           first_resource,
    output logic [4:0]           second_resource,
    output logic                 bad_request,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [5:0]           cfg_agent_count
);

    logic                   cmd_pop;
    logic                   cmd_empty;
    rnea_pkg::cmd_t         cmd_head;
    rnea_pkg::cnt_t         ring_size;
    logic                   res_full;
    logic                   res_push;
    rnea_pkg::result_t      res_word;
    rnea_pkg::result_t      head;

    rnea_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .agent_index     (agent_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_agent_count (cfg_agent_count),
        .cmd_pop         (cmd_pop),
        .cmd_empty       (cmd_empty),
        .cmd_head        (cmd_head),
        .ring_size       (ring_size)
    );

    rnea_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ring_size  (ring_size),
        .cmd_empty  (cmd_empty),
        .cmd_head   (cmd_head),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_word   (res_word)
    );

    rnea_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_push),
        .word   (res_word),
        .full   (res_full),
        .pop    (pop),
        .empty  (empty),
        .head   (head)
    );

    assign granted_agent   = head.agent;
    assign first_resource  = head.first_res;
    assign second_resource = head.second_res;
    assign bad_request     = head.bad;
    assign last            = head.last;

endmodule
